/* rtl/core/sbd_pkg.sv */
`timescale 1ns / 1ps

package sbd_pkg;

  localparam int BAND_COUNT = 7;
  localparam int LEVEL_BITS = 10;
  localparam int BAND_BITS = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  localparam int OFFSET_BITS = 10;
  localparam int FLOOR_BITS = 10;
  localparam int HOLD_CFG_BITS = 14;
  localparam int HOLD_BITS = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 14;

  localparam int CMP_W0 = (LEVEL_BITS > OFFSET_BITS) ? LEVEL_BITS : OFFSET_BITS;
  localparam int CMP_W1 = (CMP_W0 > FLOOR_BITS) ? CMP_W0 : FLOOR_BITS;
  localparam int CMP_BITS = CMP_W1 + 1;
  localparam int PROD_BITS = LEVEL_BITS + 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_OFFSET = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_FLOOR = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_HOLD = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECHECK_AFTER = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GIVE_UP_AFTER = 3'd4;

  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(0);
  localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = FLOOR_BITS'(300);
  localparam logic [HOLD_CFG_BITS-1:0] RELEASE_RESET = HOLD_CFG_BITS'(700);
  localparam logic [HOLD_CFG_BITS-1:0] RECHECK_RESET = HOLD_CFG_BITS'(1000);
  localparam logic [HOLD_CFG_BITS-1:0] GIVE_UP_RESET = HOLD_CFG_BITS'(4096);

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(50);
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  typedef logic [LEVEL_BITS-1:0] level_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]   threshold_offset;
    logic [FLOOR_BITS-1:0]    decay_floor;
    logic [HOLD_CFG_BITS-1:0] release_hold;
    logic [HOLD_CFG_BITS-1:0] recheck_after;
    logic [HOLD_CFG_BITS-1:0] give_up_after;
  } cfg_regs_t;

endpackage

/* rtl/core/sbd_cfg.sv */
`timescale 1ns / 1ps

module sbd_cfg import sbd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_regs_t                 regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold_offset <= OFFSET_RESET;
      regs.decay_floor <= FLOOR_RESET;
      regs.release_hold <= RELEASE_RESET;
      regs.recheck_after <= RECHECK_RESET;
      regs.give_up_after <= GIVE_UP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD_OFFSET: regs.threshold_offset <= cfg_data[OFFSET_BITS-1:0];
        REG_DECAY_FLOOR: regs.decay_floor <= cfg_data[FLOOR_BITS-1:0];
        REG_RELEASE_HOLD: regs.release_hold <= cfg_data[HOLD_CFG_BITS-1:0];
        REG_RECHECK_AFTER: regs.recheck_after <= cfg_data[HOLD_CFG_BITS-1:0];
        REG_GIVE_UP_AFTER: regs.give_up_after <= cfg_data[HOLD_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/sbd_core.sv */
`timescale 1ns / 1ps

module sbd_core import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  level_t    bands [BAND_COUNT],
  input  cfg_regs_t regs,
  output logic      beat
);

  logic                 in_beat;
  logic                 in_beat_next;
  logic [BAND_BITS-1:0] beat_band;
  logic [BAND_BITS-1:0] beat_band_next;
  level_t               tracked_level;
  level_t               tracked_level_next;
  logic [HOLD_BITS-1:0] hold_count;
  logic [HOLD_BITS-1:0] hold_count_next;

  always_comb begin
    logic signed [CMP_BITS-1:0] thr;
    logic                       idle_hit;
    logic [BAND_BITS-1:0]       idle_idx;
    logic [BAND_BITS-1:0]       cur_idx;
    level_t                     cur_band;
    logic                       falling;
    logic [HOLD_BITS-1:0]       hold_inc;
    logic                       re_hit;
    logic [BAND_BITS-1:0]       re_idx;

    in_beat_next = in_beat;
    beat_band_next = beat_band;
    tracked_level_next = tracked_level;
    hold_count_next = hold_count;
    beat = 1'b0;

    // idle search, lowest band wins
    thr = $signed(CMP_BITS'(tracked_level)) - $signed(CMP_BITS'(regs.threshold_offset));
    idle_hit = 1'b0;
    idle_idx = '0;
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if ($signed(CMP_BITS'(bands[i])) > thr) begin
        idle_hit = 1'b1;
        idle_idx = BAND_BITS'(i);
      end
    end

    cur_idx = (int'(beat_band) < BAND_COUNT) ? beat_band : '0;
    cur_band = bands[cur_idx];
    falling = (PROD_BITS'(cur_band) * PROD_BITS'(5)) < (PROD_BITS'(tracked_level) << 1);
    hold_inc = (hold_count != HOLD_MAX) ? hold_count + HOLD_BITS'(1) : hold_count;

    // lower bands retrigger
    re_hit = 1'b0;
    re_idx = '0;
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if ((i < int'(cur_idx)) && (bands[i] > tracked_level)) begin
        re_hit = 1'b1;
        re_idx = BAND_BITS'(i);
      end
    end

    if (!in_beat) begin
      if (idle_hit) begin
        in_beat_next = 1'b1;
        beat_band_next = idle_idx;
        tracked_level_next = bands[idle_idx];
        hold_count_next = '0;
        beat = 1'b1;
      end else if (CMP_BITS'(tracked_level) > CMP_BITS'(regs.decay_floor)) begin
        tracked_level_next = tracked_level - LEVEL_BITS'(1);
      end
    end else if (falling && (hold_count >= HOLD_BITS'(regs.release_hold))) begin
      in_beat_next = 1'b0;
      hold_count_next = '0;
    end else begin
      hold_count_next = hold_inc;
      if ((hold_inc >= HOLD_BITS'(regs.recheck_after)) && re_hit) begin
        beat_band_next = re_idx;
        tracked_level_next = bands[re_idx];
        hold_count_next = '0;
        beat = 1'b1;
      end else if (hold_inc > HOLD_BITS'(regs.give_up_after)) begin
        in_beat_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_beat <= 1'b0;
      beat_band <= '0;
      tracked_level <= LEVEL_RESET;
      hold_count <= '0;
    end else if (en) begin
      in_beat <= in_beat_next;
      beat_band <= beat_band_next;
      tracked_level <= tracked_level_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

/* rtl/core/spectrum_beat_detector_top.sv */
`timescale 1ns / 1ps
// spectrum beat detector
// input channel: in_valid / in_stall with band_0 .. band_6, one frame per item
// output channel: out_valid / out_stall with beat_found, one result per item
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data, always ready;
//   index 0 threshold_offset, 1 decay_floor, 2 release_hold, 3 recheck_after,
//   4 give_up_after; other indexes are ignored; write only while idle
// flow: an accepted item waits in the input register; when it advances, the
//   decision runs and loads the result register, which raises out_valid
// throughput: one item per cycle while the receiver does not stall; the
//   detector state is one set of registers updated as each item passes
//   from the input register to the result register
// stall: while out_stall holds a full result register, the input register
//   keeps its item and in_stall rises once it is full too
// reset: both registers empty, tracked level 50, idle, config at defaults
module spectrum_beat_detector_top import sbd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [LEVEL_BITS-1:0]     band_0,
  input  logic [LEVEL_BITS-1:0]     band_1,
  input  logic [LEVEL_BITS-1:0]     band_2,
  input  logic [LEVEL_BITS-1:0]     band_3,
  input  logic [LEVEL_BITS-1:0]     band_4,
  input  logic [LEVEL_BITS-1:0]     band_5,
  input  logic [LEVEL_BITS-1:0]     band_6,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      beat_found,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_regs_t regs;
  level_t    bands [BAND_COUNT];
  logic      s1_valid;
  logic      accept;
  logic      advance;
  logic      beat;

  sbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign advance = s1_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bands[0] <= band_0;
      bands[1] <= band_1;
      bands[2] <= band_2;
      bands[3] <= band_3;
      bands[4] <= band_4;
      bands[5] <= band_5;
      bands[6] <= band_6;
    end
  end

  sbd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .bands (bands),
    .regs  (regs),
    .beat  (beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_found <= beat;
    end
  end

endmodule

/* tb/tb_spectrum_beat_detector_top.sv */
`timescale 1ns / 1ps

import sbd_pkg::*;

typedef level_t [BAND_COUNT-1:0] frame_t;

class beat_scoreboard;
  logic [OFFSET_BITS-1:0]   offset;
  logic [FLOOR_BITS-1:0]    floor_level;
  logic [HOLD_CFG_BITS-1:0] release_min;
  logic [HOLD_CFG_BITS-1:0] recheck_min;
  logic [HOLD_CFG_BITS-1:0] give_up_max;

  bit                  in_beat;
  logic [BAND_BITS-1:0] beat_band;
  level_t              level;
  logic [HOLD_BITS-1:0] hold;

  bit beat_q[$];
  int errors;
  int frames;
  int beats;
  int results;

  function new();
    offset = OFFSET_RESET;
    floor_level = FLOOR_RESET;
    release_min = RELEASE_RESET;
    recheck_min = RECHECK_RESET;
    give_up_max = GIVE_UP_RESET;
    in_beat = 0;
    beat_band = '0;
    level = LEVEL_RESET;
    hold = '0;
  endfunction

  function int pending();
    return beat_q.size();
  endfunction

  function void apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_THRESHOLD_OFFSET: offset = data[OFFSET_BITS-1:0];
      REG_DECAY_FLOOR: floor_level = data[FLOOR_BITS-1:0];
      REG_RELEASE_HOLD: release_min = data[HOLD_CFG_BITS-1:0];
      REG_RECHECK_AFTER: recheck_min = data[HOLD_CFG_BITS-1:0];
      REG_GIVE_UP_AFTER: give_up_max = data[HOLD_CFG_BITS-1:0];
      default: ;
    endcase
  endfunction

  function void start_beat(input int band_idx, input level_t band_level);
    level = band_level;
    hold = '0;
    in_beat = 1;
    beat_band = BAND_BITS'(band_idx);
  endfunction

  function void note_frame(input frame_t f);
    int thr;
    int idx;
    bit hit;
    hit = 0;
    frames++;
    if (!in_beat) begin
      thr = int'(level) - int'(offset);
      for (int i = 0; i < BAND_COUNT; i++) begin
        if (!hit && int'(f[i]) > thr) begin
          start_beat(i, f[i]);
          hit = 1;
        end
      end
      if (!hit && level > floor_level)
        level = level - 1'b1;
    end else begin
      idx = (int'(beat_band) < BAND_COUNT) ? int'(beat_band) : 0;
      if (int'(f[idx]) * 5 < int'(level) * 2 && hold >= release_min) begin
        in_beat = 0;
        hold = '0;
      end else begin
        if (hold != HOLD_MAX)
          hold = hold + 1'b1;
        if (hold >= recheck_min) begin
          for (int i = 0; i < idx; i++) begin
            if (!hit && f[i] > level) begin
              start_beat(i, f[i]);
              hit = 1;
            end
          end
        end
        if (!hit && hold > give_up_max)
          in_beat = 0;
      end
    end
    if (hit)
      beats++;
    beat_q.push_back(hit);
  endfunction

  task report(input string msg);
    errors++;
    if (errors <= 40)
      $display("mismatch: %s", msg);
  endtask

  task check_result(input logic got);
    bit want;
    results++;
    if (beat_q.size() == 0) begin
      report($sformatf("beat_found=%b with no frame outstanding", got));
    end else begin
      want = beat_q.pop_front();
      if (got !== want)
        report($sformatf("result %0d: beat_found=%b, predicted %b", results, got, want));
    end
  endtask
endclass

module tb_spectrum_beat_detector_top;

  localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_TOP = {CFG_INDEX_BITS{1'b1}};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  frame_t band_bus;
  logic out_valid;
  logic out_stall;
  logic beat_found;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  beat_scoreboard sb;
  int sender_idle;
  int receiver_stall;
  int reg_writes;

  spectrum_beat_detector_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .band_0(band_bus[0]),
    .band_1(band_bus[1]),
    .band_2(band_bus[2]),
    .band_3(band_bus[3]),
    .band_4(band_bus[4]),
    .band_5(band_bus[5]),
    .band_6(band_bus[6]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .beat_found(beat_found),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d frames still outstanding", sb.pending());
    $display("tb_spectrum_beat_detector_top failed");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(beat_found);
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < receiver_stall);
    end
  end

  function automatic frame_t bands_of(input int b0, b1, b2, b3, b4, b5, b6);
    frame_t f;
    f[0] = level_t'(b0);
    f[1] = level_t'(b1);
    f[2] = level_t'(b2);
    f[3] = level_t'(b3);
    f[4] = level_t'(b4);
    f[5] = level_t'(b5);
    f[6] = level_t'(b6);
    return f;
  endfunction

  // bias bands toward the tracked level, the idle threshold and the release edge
  function automatic frame_t rand_frame();
    frame_t f;
    int lvl;
    int center;
    int pick;
    int v;
    bit quiet;
    lvl = int'(sb.level);
    center = sb.in_beat ? lvl : lvl - int'(sb.offset);
    quiet = ($urandom_range(0, 99) < 12);
    for (int i = 0; i < BAND_COUNT; i++) begin
      pick = $urandom_range(0, 99);
      if (quiet || pick < 22)
        v = $urandom_range(0, (lvl * 2) / 5);
      else if (pick < 55)
        v = center + int'($urandom_range(0, 6)) - 3;
      else if (pick < 65)
        v = (lvl * 2) / 5 + int'($urandom_range(0, 2)) - 1;
      else if (pick < 75)
        v = $urandom_range(0, 1) ? LEVEL_MAX : 0;
      else
        v = $urandom_range(0, LEVEL_MAX);
      if (v < 0)
        v = 0;
      if (v > LEVEL_MAX)
        v = LEVEL_MAX;
      f[i] = level_t'(v);
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    band_bus <= f;
    do @(posedge clk); while (in_stall);
    sb.note_frame(f);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  // upper data bits beyond a register's width are junk and must be dropped
  task automatic set_config(input int ofs, input int flr, input int rel,
                            input int rchk, input int gup);
    write_reg(REG_THRESHOLD_OFFSET, {4'($urandom), 10'(ofs)});
    write_reg(REG_DECAY_FLOOR, {4'($urandom), 10'(flr)});
    write_reg(REG_RELEASE_HOLD, CFG_DATA_BITS'(rel));
    write_reg(REG_RECHECK_AFTER, CFG_DATA_BITS'(rchk));
    write_reg(REG_GIVE_UP_AFTER, CFG_DATA_BITS'(gup));
    write_reg(CFG_INDEX_BITS'($urandom_range(REG_GIVE_UP_AFTER + 1, REG_INDEX_TOP)),
              CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int count;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    band_bus = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_writes = 0;
    sender_idle = 6;
    receiver_stall = 83;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: trigger on the top band, release edge held by the minimum hold
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 1023));
    send_frame(bands_of(1023, 1023, 1023, 1023, 1023, 1023, 1023));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 409));
    send_frame(bands_of(1023, 0, 0, 0, 0, 0, 1023));
    in_valid <= 1'b0;
    drain();

    // release after the minimum hold, then decay
    set_config(0, 0, 3, 2, 5);
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 409));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 409));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;
    drain();

    // offset above level: negative threshold, then give-up
    set_config(1023, 0, 3, 2, 5);
    for (int i = 0; i < 8; i++)
      send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;
    drain();

    // lower band retrigger, release with no hold, no decay at top floor
    set_config(0, 1023, 0, 0, 1);
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    send_frame(bands_of(0, 0, 0, 0, 0, 700, 0));
    send_frame(bands_of(0, 0, 701, 0, 0, 700, 0));
    send_frame(bands_of(0, 0, 280, 0, 0, 0, 0));
    send_frame(bands_of(0, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;
    drain();

    for (int m = 0; m < 3; m++) begin
      sender_idle = (m == 0) ? 6 : (m == 1) ? 83 : 0;
      receiver_stall = (m == 0) ? 83 : (m == 1) ? 6 : 0;
      for (int p = 0; p < 4; p++) begin
        case (p)
          0: set_config(0, 0, 0, 0, 0);
          1: set_config(1023, 1023, 16383, 16383, 16383);
          default: set_config($urandom_range(0, 99) < 70 ? $urandom_range(0, 80)
                                                         : $urandom_range(0, LEVEL_MAX),
                              $urandom_range(0, LEVEL_MAX), $urandom_range(0, 12),
                              $urandom_range(0, 20), $urandom_range(0, 40));
        endcase
        count = (p == 1) ? 40 : 140;
        for (int n = 0; n < count; n++) begin
          if (n == count / 2) begin
            in_valid <= 1'b0;
            drain();
          end
          send_frame(rand_frame());
        end
        in_valid <= 1'b0;
        drain();
      end
    end

    repeat (10) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    $display("covered %0d frames, %0d predicted beats, %0d register writes",
             sb.frames, sb.beats, reg_writes);
    $display("idling swept sender-heavy, receiver-heavy and none; %0d results checked",
             sb.results);
    if (sb.errors == 0)
      $display("tb_spectrum_beat_detector_top passed");
    else
      $display("tb_spectrum_beat_detector_top failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sbd_pkg.sv
rtl/core/sbd_cfg.sv
rtl/core/sbd_core.sv
rtl/core/spectrum_beat_detector_top.sv
tb/tb_spectrum_beat_detector_top.sv
